/* rtl/masked_byte_signature_scan_assert.svh */
`ifndef MASKED_BYTE_SIGNATURE_SCAN_ASSERT_SVH
`define MASKED_BYTE_SIGNATURE_SCAN_ASSERT_SVH

// check a property every clock edge outside reset
`define MBSS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that a signal holds in the cycle after a condition
`define MBSS_ASSERT_HOLD(label, cond, sig, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> $stable(sig)) \
      else $error(msg);

`endif

/* rtl/mbss_pkg.sv */
package mbss_pkg;

   localparam int PATTERN_BYTES = 16;
   localparam int BYTE_W        = 8;
   localparam int WORD_W        = 64;
   localparam int CARE_W        = 16;
   localparam int CFG_LEN_W     = 5;
   localparam int ADDR_W        = 32;
   localparam int COUNT_W       = 32;
   localparam int CSR_IDX_W     = 3;
   localparam int EFF_LEN_W     = $clog2(PATTERN_BYTES + 1);
   localparam int POS_W         = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_CARE_MASK      = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3,
      CSR_SCAN_BASE      = 3'd4
   } csr_index_type;

   typedef logic [PATTERN_BYTES-1:0][BYTE_W-1:0] window_type;

   typedef struct packed {
      window_type                 pattern;
      logic [PATTERN_BYTES-1:0]   care;
      logic [EFF_LEN_W-1:0]       length;
      logic [ADDR_W-1:0]          base;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last;
      logic [COUNT_W-1:0] count;
   } stage_type;

endpackage

/* rtl/mbss_if.sv */
interface mbss_req_if;
   import mbss_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] byte_value;
   logic              first_byte;
   logic              last_byte;
   modport source (output valid, byte_value, first_byte, last_byte, input ready);
   modport sink (input valid, byte_value, first_byte, last_byte, output ready);
endinterface

interface mbss_rsp_if;
   import mbss_pkg::*;
   logic              valid;
   logic              ready;
   logic              found;
   logic [ADDR_W-1:0] match_address;
   modport source (output valid, found, match_address, input ready);
   modport sink (input valid, found, match_address, output ready);
endinterface

interface mbss_csr_if;
   import mbss_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/mbss_csr.sv */
module mbss_csr (
   input  logic               clock,
   input  logic               reset,
   mbss_csr_if.sink           csr_chan,
   output mbss_pkg::cfg_type  cfg
);
   import mbss_pkg::*;

   logic [WORD_W-1:0]    pattern_low_ff;
   logic [WORD_W-1:0]    pattern_high_ff;
   logic [CARE_W-1:0]    care_mask_ff;
   logic [CFG_LEN_W-1:0] pattern_length_ff;
   logic [ADDR_W-1:0]    scan_base_ff;
   logic [2*WORD_W-1:0]  pattern_bits;
   logic                 write;

   assign csr_chan.ready = 1'b1;
   assign write = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '1;
         pattern_length_ff <= CFG_LEN_W'(16);
         scan_base_ff      <= '0;
      end else if (write) begin
         case (csr_chan.index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_chan.data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_chan.data;
            CSR_CARE_MASK:      care_mask_ff      <= csr_chan.data[CARE_W-1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_chan.data[CFG_LEN_W-1:0];
            CSR_SCAN_BASE:      scan_base_ff      <= csr_chan.data[ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   assign pattern_bits = {pattern_high_ff, pattern_low_ff};

   always_comb begin
      for (int i = 0; i < PATTERN_BYTES; i++) begin
         cfg.pattern[i] = pattern_bits[i*BYTE_W +: BYTE_W];
         cfg.care[i]    = (pattern_length_ff != '0) && care_mask_ff[i];
      end
      if (pattern_length_ff == '0) begin
         cfg.length = EFF_LEN_W'(1);
      end else if (pattern_length_ff > CFG_LEN_W'(PATTERN_BYTES)) begin
         cfg.length = EFF_LEN_W'(PATTERN_BYTES);
      end else begin
         cfg.length = EFF_LEN_W'(pattern_length_ff);
      end
      cfg.base = scan_base_ff;
   end

endmodule

/* rtl/mbss_window.sv */
module mbss_window (
   input  logic                 clock,
   input  logic                 reset,
   mbss_req_if.sink             req_chan,
   input  logic                 advance,
   output mbss_pkg::stage_type  stage,
   output mbss_pkg::window_type window
);
   import mbss_pkg::*;

   window_type         window_ff;
   window_type         window_in;
   window_type         window_base;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               valid_ff;
   logic               first_ff;
   logic               last_ff;
   logic               accept;

   assign req_chan.ready = !reset && (!valid_ff || advance);
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      window_base = req_chan.first_byte ? '0 : window_ff;
      for (int i = PATTERN_BYTES - 1; i > 0; i--) begin
         window_in[i] = window_base[i-1];
      end
      window_in[0] = req_chan.byte_value;
      if (req_chan.first_byte) begin
         count_in = COUNT_W'(1);
      end else if (count_ff == '1) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         window_ff <= '0;
         count_ff  <= '0;
      end else if (accept) begin
         valid_ff  <= 1'b1;
         window_ff <= window_in;
         count_ff  <= count_in;
      end else if (advance) begin
         valid_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff <= req_chan.first_byte;
         last_ff  <= req_chan.last_byte;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.first = first_ff;
   assign stage.last  = last_ff;
   assign stage.count = count_ff;
   assign window      = window_ff;

endmodule

/* rtl/mbss_match.sv */
module mbss_match (
   input  logic                 clock,
   input  logic                 reset,
   input  mbss_pkg::cfg_type    cfg,
   input  mbss_pkg::stage_type  stage,
   input  mbss_pkg::window_type window,
   output logic                 advance,
   mbss_rsp_if.source           rsp_chan
);
   import mbss_pkg::*;

   logic                 done_ff;
   logic                 done_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 found_ff;
   logic                 found_in;
   logic [ADDR_W-1:0]    address_ff;
   logic [ADDR_W-1:0]    address_in;
   logic                 hit;
   logic                 match;
   logic                 open;
   logic                 take;
   logic [EFF_LEN_W-1:0] pos [PATTERN_BYTES];
   logic [COUNT_W-1:0]   offset;

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign take    = stage.valid && advance;
   assign open    = stage.first || !done_ff;

   always_comb begin
      hit = 1'b1;
      for (int i = 0; i < PATTERN_BYTES; i++) begin
         pos[i] = cfg.length - EFF_LEN_W'(1) - EFF_LEN_W'(i);
         if ((EFF_LEN_W'(i) < cfg.length) && cfg.care[i]
               && (window[pos[i][POS_W-1:0]] != cfg.pattern[i])) begin
            hit = 1'b0;
         end
      end
   end

   assign match  = hit && (stage.count >= COUNT_W'(cfg.length));
   assign offset = stage.count - COUNT_W'(cfg.length);

   always_comb begin
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      found_in     = found_ff;
      address_in   = address_ff;
      if (take) begin
         if (stage.first) begin
            done_in = 1'b0;
         end
         if (open && (match || stage.last)) begin
            done_in      = 1'b1;
            rsp_valid_in = 1'b1;
            found_in     = match;
            address_in   = match ? cfg.base + ADDR_W'(offset) : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff   <= found_in;
      address_ff <= address_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.found         = found_ff;
   assign rsp_chan.match_address = address_ff;

endmodule

/* rtl/masked_byte_signature_scan.sv */
// Masked byte signature scan: finds the first place in a byte stream where a pattern of up to
// 16 bytes appears, each pattern byte either compared or a wildcard by the care mask, and
// returns scan_base plus the match offset (or found = 0 and address 0 when the byte marked
// last passes without a match). The block takes one byte per clock unless a result is held
// by the receiver: the accepted byte is shifted into a window register, the window is
// compared against the pattern in parallel, and the answer is registered in the result
// register. A byte with first_byte set opens a new scan; bytes after a result are dropped
// until then. Write the configuration registers only while no scan is in flight.
module masked_byte_signature_scan (
   input  logic       clock,
   input  logic       reset,
   mbss_req_if.sink   req_chan,
   mbss_rsp_if.source rsp_chan,
   mbss_csr_if.sink   csr_chan
);
   import mbss_pkg::*;

   cfg_type    cfg;
   stage_type  stage;
   window_type window;
   logic       advance;

   mbss_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   mbss_window u_window (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .stage    (stage),
      .window   (window)
   );

   mbss_match u_match (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .stage    (stage),
      .window   (window),
      .advance  (advance),
      .rsp_chan (rsp_chan)
   );

endmodule

/* rtl/mbss_checker.sv */
`include "masked_byte_signature_scan_assert.svh"

module mbss_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_found,
   input logic [mbss_pkg::ADDR_W-1:0] rsp_address
);
   import mbss_pkg::*;

   `MBSS_ASSERT(rsp_valid_holds, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `MBSS_ASSERT_HOLD(rsp_addr_holds, rsp_valid && !rsp_ready, rsp_address, "rsp changed")
   `MBSS_ASSERT(miss_has_zero_addr, rsp_valid && !rsp_found |-> rsp_address == '0, "bad miss")
   `MBSS_ASSERT(rsp_follows_req, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "no req")

endmodule

bind masked_byte_signature_scan mbss_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_found   (rsp_chan.found),
   .rsp_address (rsp_chan.match_address)
);

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
   import mbss_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int ROUND_ITEMS  = 105;

   typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_RESULT} check_kind_type;
   typedef enum logic [1:0] {PACE_RECV_SLOW, PACE_SEND_SLOW, PACE_FULL} pace_type;
   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic              found;
      logic [ADDR_W-1:0] addr;
   } match_result_type;

   typedef struct {
      logic [BYTE_W-1:0] value;
      logic              is_first;
      logic              is_last;
      check_kind_type    chk;
      logic              found;
      logic [ADDR_W-1:0] addr;
   } byte_item_type;

   typedef struct {
      row_kind_type      kind;
      csr_index_type     idx;
      logic [WORD_W-1:0] data;
      byte_item_type     item;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mbss_req_if req_if ();
   mbss_rsp_if rsp_if ();
   mbss_csr_if csr_if ();

   masked_byte_signature_scan i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   // configuration as the block should hold it
   logic [WORD_W-1:0]    cfg_pattern_low;
   logic [WORD_W-1:0]    cfg_pattern_high;
   logic [CARE_W-1:0]    cfg_care;
   logic [CFG_LEN_W-1:0] cfg_length;
   logic [ADDR_W-1:0]    cfg_base;

   // scan state as the block should hold it
   window_type           scan_window;
   logic [COUNT_W-1:0]   scan_count;
   logic                 scan_closed;

   byte_item_type        byte_queue[$];
   match_result_type     pending_results[$];
   directed_row_type     directed_rows[$];
   int unsigned          queued_count = 0;
   int unsigned          taken_count  = 0;
   int unsigned          mismatches   = 0;
   int unsigned          quiet_cycles = 0;
   pace_type             pace_mode    = PACE_RECV_SLOW;
   logic                 hold_req     = 1'b0;
   logic                 hold_taken   = 1'b0;
   int unsigned          hold_left    = 0;

   byte_item_type        on_offer;
   logic                 offer_live = 1'b0;
   logic                 produced;
   match_result_type     predicted;
   match_result_type     awaited;

   function automatic int effective_length();
      int n;
      n = int'(cfg_length);
      if (n == 0) n = 1;
      if (n > PATTERN_BYTES) n = PATTERN_BYTES;
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] pattern_at(input int k);
      if (k < 8) return cfg_pattern_low[8*k +: 8];
      return cfg_pattern_high[8*(k-8) +: 8];
   endfunction

   function automatic logic advance_scan(input logic [BYTE_W-1:0] value, input logic is_first,
                                         input logic is_last, output match_result_type res);
      int   span;
      logic hit;
      span = effective_length();
      res  = '0;
      if (is_first) begin
         scan_window = '0;
         scan_count  = '0;
         scan_closed = 1'b0;
      end
      if (scan_closed) return 1'b0;
      scan_window = {scan_window[PATTERN_BYTES-2:0], value};
      if (scan_count != '1) scan_count = scan_count + 1'b1;
      hit = (scan_count >= COUNT_W'(span));
      for (int k = 0; k < span; k++) begin
         if (cfg_length != '0 && cfg_care[k] && scan_window[span-1-k] != pattern_at(k))
            hit = 1'b0;
      end
      if (hit) begin
         scan_closed = 1'b1;
         res.found   = 1'b1;
         res.addr    = cfg_base + (scan_count - COUNT_W'(span));
         return 1'b1;
      end
      if (is_last) begin
         scan_closed = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic sender_waits();
      case (pace_mode)
         PACE_RECV_SLOW: return $urandom_range(0, 99) < 11;
         PACE_SEND_SLOW: return $urandom_range(0, 99) < 70;
         default:        return 1'b0;
      endcase
   endfunction

   function automatic logic receiver_waits();
      case (pace_mode)
         PACE_RECV_SLOW: return $urandom_range(0, 99) < 70;
         PACE_SEND_SLOW: return $urandom_range(0, 99) < 11;
         default:        return 1'b0;
      endcase
   endfunction

   task automatic report(input string what, input logic [ADDR_W-1:0] got,
                         input logic [ADDR_W-1:0] want);
      $display("tb: mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   task automatic push_item(input byte_item_type it);
      byte_queue.push_back(it);
      queued_count++;
   endtask

   task automatic row_byte(input logic [BYTE_W-1:0] value, input logic is_first,
                           input logic is_last, input check_kind_type chk, input logic found,
                           input logic [ADDR_W-1:0] addr);
      directed_row_type row;
      row.kind          = ROW_BYTE;
      row.item.value    = value;
      row.item.is_first = is_first;
      row.item.is_last  = is_last;
      row.item.chk      = chk;
      row.item.found    = found;
      row.item.addr     = addr;
      directed_rows.push_back(row);
   endtask

   task automatic row_csr(input csr_index_type idx, input logic [WORD_W-1:0] data);
      directed_row_type row;
      row.kind = ROW_CSR;
      row.idx  = idx;
      row.data = data;
      directed_rows.push_back(row);
   endtask

   task automatic wait_idle();
      while (taken_count != queued_count || pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [WORD_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!(csr_if.valid && csr_if.ready));
      case (idx)
         CSR_PATTERN_LOW:    cfg_pattern_low  = value;
         CSR_PATTERN_HIGH:   cfg_pattern_high = value;
         CSR_CARE_MASK:      cfg_care         = value[CARE_W-1:0];
         CSR_PATTERN_LENGTH: cfg_length       = value[CFG_LEN_W-1:0];
         CSR_SCAN_BASE:      cfg_base         = value[ADDR_W-1:0];
         default: ;
      endcase
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic randomize_config();
      logic [WORD_W-1:0] word;
      word = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: word = '0;
         1: word = '1;
         default: ;
      endcase
      write_csr(CSR_PATTERN_LOW, word);
      word = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: word = '0;
         1: word = '1;
         default: ;
      endcase
      write_csr(CSR_PATTERN_HIGH, word);
      case ($urandom_range(0, 5))
         0: word = 64'h0;
         1: word = 64'hFFFF;
         default: word = WORD_W'($urandom_range(0, 65535));
      endcase
      write_csr(CSR_CARE_MASK, word);
      case ($urandom_range(0, 7))
         0: word = '0;
         1: word = WORD_W'($urandom_range(PATTERN_BYTES + 1, 31));
         2: word = WORD_W'(PATTERN_BYTES);
         3: word = WORD_W'(1);
         default: word = WORD_W'($urandom_range(1, PATTERN_BYTES));
      endcase
      write_csr(CSR_PATTERN_LENGTH, word);
      case ($urandom_range(0, 4))
         0: word = '0;
         1: word = WORD_W'(32'hFFFF_FFF0 + $urandom_range(0, 15));
         2: word = 64'hFFFF_FFFF;
         default: word = WORD_W'($urandom);
      endcase
      write_csr(CSR_SCAN_BASE, word);
   endtask

   task automatic gen_scans(input int target);
      int            made, lead, tail, span, total;
      logic          embed;
      byte_item_type it;
      made     = 0;
      it.chk   = CHK_PREDICT;
      it.found = 1'b0;
      it.addr  = '0;
      while (made < target) begin
         if ($urandom_range(0, 99) < 12) begin
            it.value    = BYTE_W'($urandom_range(0, 255));
            it.is_first = ($urandom_range(0, 3) == 0);
            it.is_last  = ($urandom_range(0, 3) == 0);
            push_item(it);
            made++;
         end else begin
            span  = effective_length();
            embed = ($urandom_range(0, 99) < 65);
            lead  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 5);
            tail  = embed ? $urandom_range(0, 3) : $urandom_range(1, 12);
            total = lead + (embed ? span : 0) + tail;
            for (int k = 0; k < total; k++) begin
               if (embed && k >= lead && k < lead + span && cfg_length != '0 && cfg_care[k-lead])
                  it.value = pattern_at(k - lead);
               else if ($urandom_range(0, 2) == 0)
                  it.value = pattern_at($urandom_range(0, PATTERN_BYTES - 1));
               else
                  it.value = BYTE_W'($urandom_range(0, 255));
               it.is_first = (k == 0);
               it.is_last  = (k == total - 1) && ($urandom_range(0, 9) != 0);
               push_item(it);
               made++;
            end
         end
      end
   endtask

   // byte channel: offer items, predict each transfer
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            produced = advance_scan(on_offer.value, on_offer.is_first, on_offer.is_last,
                                    predicted);
            case (on_offer.chk)
               CHK_PREDICT: if (produced) pending_results.push_back(predicted);
               CHK_RESULT:  pending_results.push_back({on_offer.found, on_offer.addr});
               default: ;
            endcase
            taken_count++;
            offer_live = 1'b0;
         end
         if (!offer_live && byte_queue.size() != 0 && !sender_waits()) begin
            on_offer   = byte_queue.pop_front();
            offer_live = 1'b1;
            req_if.byte_value <= on_offer.value;
            req_if.first_byte <= on_offer.is_first;
            req_if.last_byte  <= on_offer.is_last;
         end
         req_if.valid <= offer_live;
      end
   end

   // result channel: check each transfer, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               report("result with none awaited", rsp_if.match_address, '0);
            end else begin
               awaited = pending_results.pop_front();
               if (rsp_if.found !== awaited.found)
                  report("found", ADDR_W'(rsp_if.found), ADDR_W'(awaited.found));
               if (rsp_if.match_address !== awaited.addr)
                  report("match_address", rsp_if.match_address, awaited.addr);
            end
         end
         if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !receiver_waits();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      req_if.valid      = 1'b0;
      req_if.byte_value = '0;
      req_if.first_byte = 1'b0;
      req_if.last_byte  = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = '0;
      csr_if.data       = '0;
      cfg_pattern_low   = '0;
      cfg_pattern_high  = '0;
      cfg_care          = '1;
      cfg_length        = CFG_LEN_W'(PATTERN_BYTES);
      cfg_base          = '0;
      scan_window       = '0;
      scan_count        = '0;
      scan_closed       = 1'b0;

      row_byte(8'hFF, 1'b1, 1'b1, CHK_RESULT,  1'b0, 32'h0);
      row_byte(8'h00, 1'b0, 1'b1, CHK_NONE,    1'b0, 32'h0);
      row_csr(CSR_PATTERN_LENGTH, 64'd0);
      row_csr(CSR_SCAN_BASE, 64'hFFFF_FFFF);
      row_byte(8'hA5, 1'b1, 1'b0, CHK_RESULT,  1'b1, 32'hFFFF_FFFF);
      row_byte(8'h5A, 1'b0, 1'b1, CHK_NONE,    1'b0, 32'h0);
      row_csr(CSR_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_00FF);
      row_csr(CSR_PATTERN_LENGTH, 64'd2);
      row_csr(CSR_SCAN_BASE, 64'h10);
      row_byte(8'hFF, 1'b1, 1'b0, CHK_PREDICT, 1'b0, 32'h0);
      row_byte(8'h00, 1'b0, 1'b1, CHK_RESULT,  1'b1, 32'h10);
      row_byte(8'h00, 1'b1, 1'b0, CHK_PREDICT, 1'b0, 32'h0);
      row_byte(8'hFF, 1'b0, 1'b0, CHK_PREDICT, 1'b0, 32'h0);
      row_byte(8'hFF, 1'b1, 1'b0, CHK_PREDICT, 1'b0, 32'h0);
      row_byte(8'h00, 1'b0, 1'b0, CHK_RESULT,  1'b1, 32'h10);
      row_csr(CSR_CARE_MASK, 64'h1);
      row_csr(CSR_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      row_csr(CSR_SCAN_BASE, 64'hFFFF_FFFF);
      row_byte(8'h12, 1'b1, 1'b0, CHK_PREDICT, 1'b0, 32'h0);
      row_byte(8'hFF, 1'b0, 1'b0, CHK_PREDICT, 1'b0, 32'h0);
      row_byte(8'h34, 1'b0, 1'b0, CHK_RESULT,  1'b1, 32'h0);
      row_csr(CSR_PATTERN_LENGTH, 64'd31);
      row_csr(CSR_CARE_MASK, 64'h0);
      row_csr(CSR_SCAN_BASE, 64'h100);
      row_byte(8'h00, 1'b1, 1'b0, CHK_PREDICT, 1'b0, 32'h0);
      row_byte(8'h80, 1'b0, 1'b0, CHK_PREDICT, 1'b0, 32'h0);
      row_byte(8'h7F, 1'b0, 1'b1, CHK_RESULT,  1'b0, 32'h0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            wait_idle();
            write_csr(directed_rows[r].idx, directed_rows[r].data);
         end else begin
            push_item(directed_rows[r].item);
         end
      end

      for (int p = 0; p < 3; p++) begin
         for (int round = 0; round < 3; round++) begin
            wait_idle();
            randomize_config();
            pace_mode = pace_type'(p);
            // hold the result side off while the byte side keeps offering
            if (pace_mode == PACE_FULL && round == 0) hold_req <= 1'b1;
            gen_scans(ROUND_ITEMS);
         end
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
